@@ rtl/core/iaid_pkg.sv @@
// Shared types, codes and widths of the indexed array insert/delete block.
// Used by the channel interfaces, the controller, the datapath and the checker.
`default_nettype none

package iaid_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int CMD_W     = 2;
	localparam int POS_W     = 4;
	localparam int DATA_W    = 32;
	localparam int FILL_W    = 5;
	localparam int STAT_W    = 2;

	localparam logic [FILL_W-1:0] CAP_RESET = 5'd16;

	// request command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// datapath array operations
	typedef logic [1:0] op_t;
	localparam op_t OP_HOLD   = 2'd0;
	localparam op_t OP_INSERT = 2'd1;
	localparam op_t OP_DELETE = 2'd2;
	localparam op_t OP_ROTATE = 2'd3;

	typedef struct packed {
		op_t               op;
		logic              load;
		logic              take_entry;
		logic [STAT_W-1:0] status;
	} dp_cmd_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic              ins_bad_pos;
		logic              ins_full;
		logic              del_bad_pos;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/iaid_if.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on iaid_pkg for field widths.
`default_nettype none

interface iaid_req_if;
	logic                                valid;
	logic                                ready;
	logic [iaid_pkg::CMD_W-1:0]          cmd;
	logic [iaid_pkg::POS_W-1:0]          position;
	logic signed [iaid_pkg::DATA_W-1:0]  new_value;

	modport source (output valid, cmd, position, new_value, input ready);
	modport sink (input valid, cmd, position, new_value, output ready);
endinterface

interface iaid_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [iaid_pkg::STAT_W-1:0]         status;
	logic [iaid_pkg::FILL_W-1:0]         fill_after;
	logic signed [iaid_pkg::DATA_W-1:0]  entry_value;
	logic                                last;

	modport source (output valid, status, fill_after, entry_value, last, input ready);
	modport sink (input valid, status, fill_after, entry_value, last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/iaid_datapath.sv @@
// Entry register chain, fill count, capacity register and result registers.
// Driven by the controller through iaid_pkg::dp_cmd_t; depends on iaid_pkg.
`default_nettype none

module iaid_datapath #(
	parameter int DEPTH = iaid_pkg::DEPTH_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [iaid_pkg::FILL_W-1:0]         cfg_wdata,
	input  wire [iaid_pkg::POS_W-1:0]          position,
	input  wire signed [iaid_pkg::DATA_W-1:0]  new_value,
	input  wire iaid_pkg::dp_cmd_t             cmd,
	output iaid_pkg::dp_stat_t                 stat,
	output logic [iaid_pkg::STAT_W-1:0]        status,
	output logic [iaid_pkg::FILL_W-1:0]        fill_after,
	output logic signed [iaid_pkg::DATA_W-1:0] entry_value
);

	localparam int FW = iaid_pkg::FILL_W;
	localparam int CW = ($clog2(DEPTH + 1) > FW) ? $clog2(DEPTH + 1) : FW;

	logic [FW-1:0]                      cap_q;
	logic [FW-1:0]                      fill_q;
	logic [FW-1:0]                      fill_nxt;
	logic [FW-1:0]                      cap_eff;
	logic [CW-1:0]                      fill_ext;
	logic [CW-1:0]                      pos_ext;
	logic signed [iaid_pkg::DATA_W-1:0] ent_q    [DEPTH];
	logic signed [iaid_pkg::DATA_W-1:0] ent_prev [DEPTH];
	logic signed [iaid_pkg::DATA_W-1:0] ent_next [DEPTH];
	logic [iaid_pkg::STAT_W-1:0]        status_q;
	logic [FW-1:0]                      fill_out_q;
	logic signed [iaid_pkg::DATA_W-1:0] value_q;

	assign fill_ext = CW'(fill_q);
	assign pos_ext  = CW'(position);

	always_comb begin
		if (CW'(cap_q) < CW'(DEPTH)) begin
			cap_eff = cap_q;
		end else begin
			cap_eff = FW'(DEPTH);
		end
	end

	always_comb begin
		stat.fill        = fill_q;
		stat.ins_bad_pos = pos_ext > fill_ext;
		stat.ins_full    = fill_q >= cap_eff;
		stat.del_bad_pos = pos_ext >= fill_ext;
	end

	always_comb begin
		case (cmd.op)
			iaid_pkg::OP_INSERT: fill_nxt = fill_q + 1'b1;
			iaid_pkg::OP_DELETE: fill_nxt = fill_q - 1'b1;
			default:             fill_nxt = fill_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= iaid_pkg::CAP_RESET;
			fill_q <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			fill_q <= fill_nxt;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_ent
			if (gi == 0) begin : g_first
				assign ent_prev[gi] = '0;
			end else begin : g_mid
				assign ent_prev[gi] = ent_q[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_top
				assign ent_next[gi] = '0;
			end else begin : g_low
				assign ent_next[gi] = ent_q[gi+1];
			end

			// all moving entries shift in the same cycle: insert shifts up, delete and
			// dump rotation shift down
			always_ff @(posedge clk) begin
				case (cmd.op)
					iaid_pkg::OP_INSERT: begin
						if (CW'(gi) == pos_ext) begin
							ent_q[gi] <= new_value;
						end else if (CW'(gi) > pos_ext && CW'(gi) <= fill_ext) begin
							ent_q[gi] <= ent_prev[gi];
						end
					end
					iaid_pkg::OP_DELETE: begin
						if (CW'(gi) >= pos_ext && CW'(gi + 1) < fill_ext) begin
							ent_q[gi] <= ent_next[gi];
						end
					end
					iaid_pkg::OP_ROTATE: begin
						// wrap the head to the top of the filled part
						if (CW'(gi + 1) < fill_ext) begin
							ent_q[gi] <= ent_next[gi];
						end else if (CW'(gi + 1) == fill_ext) begin
							ent_q[gi] <= ent_q[0];
						end
					end
					default: begin
					end
				endcase
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q   <= cmd.status;
			fill_out_q <= fill_nxt;
			value_q    <= cmd.take_entry ? ent_q[0] : '0;
		end
	end

	assign status      = status_q;
	assign fill_after  = fill_out_q;
	assign entry_value = value_q;

endmodule

`default_nettype wire

@@ rtl/core/iaid_ctrl.sv @@
// Request/result controller: decodes requests, sequences dumps, owns valid/ready.
// Commands the datapath through iaid_pkg::dp_cmd_t; depends on iaid_pkg.
`default_nettype none

module iaid_ctrl (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         req_valid,
	output logic                        req_ready,
	input  wire [iaid_pkg::CMD_W-1:0]   req_cmd,
	output logic                        rsp_valid,
	input  wire                         rsp_ready,
	output logic                        rsp_last,
	input  wire iaid_pkg::dp_stat_t     stat,
	output iaid_pkg::dp_cmd_t           cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_BUSY = 1'b1;

	logic                        state_q;
	logic                        state_d;
	logic                        last_q;
	logic                        last_d;
	logic [iaid_pkg::FILL_W-1:0] rem_q;
	logic [iaid_pkg::FILL_W-1:0] rem_d;
	logic                        accept;
	logic                        rsp_take;

	assign rsp_valid = (state_q == S_BUSY);
	assign rsp_last  = last_q;
	assign rsp_take  = rsp_valid && rsp_ready;
	assign req_ready = (state_q == S_IDLE) || (rsp_take && last_q);
	assign accept    = req_valid && req_ready;

	always_comb begin
		cmd.op         = iaid_pkg::OP_HOLD;
		cmd.load       = 1'b0;
		cmd.take_entry = 1'b0;
		cmd.status     = iaid_pkg::ST_OK;
		last_d         = last_q;
		rem_d          = rem_q;
		state_d        = state_q;
		if (accept) begin
			cmd.load = 1'b1;
			last_d   = 1'b1;
			state_d  = S_BUSY;
			case (req_cmd)
				iaid_pkg::CMD_INSERT: begin
					if (stat.ins_bad_pos) begin
						cmd.status = iaid_pkg::ST_RANGE;
					end else if (stat.ins_full) begin
						cmd.status = iaid_pkg::ST_FULL;
					end else begin
						cmd.op = iaid_pkg::OP_INSERT;
					end
				end
				iaid_pkg::CMD_DELETE: begin
					if (stat.del_bad_pos) begin
						cmd.status = iaid_pkg::ST_RANGE;
					end else begin
						cmd.op = iaid_pkg::OP_DELETE;
					end
				end
				iaid_pkg::CMD_DUMP: begin
					// emit the head and rotate; after fill rotations the array is restored
					if (stat.fill != '0) begin
						cmd.op         = iaid_pkg::OP_ROTATE;
						cmd.take_entry = 1'b1;
						rem_d          = stat.fill - 1'b1;
						last_d         = (stat.fill == iaid_pkg::FILL_W'(1));
					end
				end
				default: begin
				end
			endcase
		end else if (rsp_take) begin
			if (last_q) begin
				state_d = S_IDLE;
			end else begin
				cmd.op         = iaid_pkg::OP_ROTATE;
				cmd.load       = 1'b1;
				cmd.take_entry = 1'b1;
				rem_d          = rem_q - 1'b1;
				last_d         = (rem_q == iaid_pkg::FILL_W'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= 1'b1;
			rem_q   <= '0;
		end else begin
			state_q <= state_d;
			last_q  <= last_d;
			rem_q   <= rem_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/indexed_array_insert_delete.sv @@
// Top level of the indexed array insert/delete block.
// Depends on iaid_pkg, iaid_if, iaid_ctrl and iaid_datapath.
`default_nettype none

// Holds up to DEPTH signed 32-bit words in a register chain plus a fill count.
// Insert and delete shift every later entry in the same cycle, so each such
// request gives its single result the cycle after it is accepted, and a new
// request is taken in the same cycle the final result of the previous one is
// taken: one request per cycle when the result side does not stall. A dump
// gives one result per cycle unless stalled, fill count results in all (one
// when empty); it reads the chain head and rotates the filled part by one per
// result, leaving the array unchanged. Write the capacity only while idle.
module indexed_array_insert_delete #(
	parameter int DEPTH = iaid_pkg::DEPTH_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	iaid_req_if.sink                    req,
	iaid_rsp_if.source                  rsp,
	input  wire                         cfg_we,
	input  wire [iaid_pkg::FILL_W-1:0]  cfg_wdata
);

	iaid_pkg::dp_cmd_t  dp_cmd;
	iaid_pkg::dp_stat_t dp_stat;

	iaid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_cmd   (req.cmd),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.rsp_last  (rsp.last),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	iaid_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.position    (req.position),
		.new_value   (req.new_value),
		.cmd         (dp_cmd),
		.stat        (dp_stat),
		.status      (rsp.status),
		.fill_after  (rsp.fill_after),
		.entry_value (rsp.entry_value)
	);

endmodule

`default_nettype wire

@@ rtl/core/iaid_checker.sv @@
// Port-level checker for indexed_array_insert_delete, with its bind statement.
// Depends on iaid_pkg for status codes and widths.
`default_nettype none

module iaid_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                req_valid,
	input wire                                req_ready,
	input wire                                rsp_valid,
	input wire                                rsp_ready,
	input wire [iaid_pkg::STAT_W-1:0]         rsp_status,
	input wire [iaid_pkg::FILL_W-1:0]         rsp_fill_after,
	input wire signed [iaid_pkg::DATA_W-1:0]  rsp_entry_value,
	input wire                                rsp_last
);

	// a stalled result holds its value, last flag and status
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_value)
			&& $stable(rsp_last) && $stable(rsp_status))
		else $error("stalled result changed");

	// a rejected request gives one zero-valued result
	a_reject_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != iaid_pkg::ST_OK |-> rsp_last && rsp_entry_value == '0)
		else $error("rejected request result not single or not zero");

	// only a non-empty dump produces non-final results
	a_dump_body: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> rsp_status == iaid_pkg::ST_OK && rsp_fill_after != '0)
		else $error("non-final result outside a dump");

	// dump results follow one another without a gap
	a_dump_stream: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
		else $error("gap inside a dump");

	// a new request only enters once the previous request's results are done
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> !rsp_valid || (rsp_ready && rsp_last))
		else $error("request taken while results still pending");

endmodule

bind indexed_array_insert_delete iaid_checker u_iaid_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_fill_after  (rsp.fill_after),
	.rsp_entry_value (rsp.entry_value),
	.rsp_last        (rsp.last)
);

`default_nettype wire
